// File: hw/rtl/life_grid_automaton_unit_macros.svh
// Assertion macros used by the top level of the life grid automaton RTL.
`ifndef LIFE_GRID_AUTOMATON_UNIT_MACROS_SVH
`define LIFE_GRID_AUTOMATON_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during rst.
`define LGA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("life grid automaton assertion failed");

// Next-cycle implication, clocked on clk and disabled during rst.
`define LGA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("life grid automaton assertion failed");

`endif

// File: hw/rtl/lga_pkg.sv
// Shared types and command codes of the life grid automaton.
package lga_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       new_alive;
  } req_t;

  typedef struct packed {
    logic       cell_alive;
    logic [1:0] done_command;
  } rsp_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

endpackage

// File: hw/rtl/lga_stream_if.sv
// Valid/ready channel that carries one request or result payload.
interface lga_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/lga_cell.sv
// One column cell: holds a three-row window and computes the next state of its row bit.
module lga_cell (
  input  logic              clk,
  input  lga_pkg::cell_ctl_t ctl,
  input  logic              in_bit,
  input  logic [2:0]        left_col,
  input  logic [2:0]        right_col,
  output logic [2:0]        col,
  output logic              next_bit
);

  logic       above;
  logic       cur;
  logic [3:0] live;

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      above <= 1'b0;
      cur   <= 1'b0;
    end else if (ctl.shift) begin
      above <= cur;
      cur   <= in_bit;
    end
  end

  assign col = {above, cur, in_bit};

  assign live = 4'(left_col[2]) + 4'(left_col[1]) + 4'(left_col[0]) +
                4'(right_col[2]) + 4'(right_col[1]) + 4'(right_col[0]) +
                4'(above) + 4'(in_bit);

  assign next_bit = (live == 4'd3) || (cur && (live == 4'd2));

endmodule

// File: hw/rtl/lga_cell_row.sv
// Row of column cells that turns a sliding three-row window into one new grid row.
module lga_cell_row #(
  parameter int W = 64
) (
  input  logic               clk,
  input  lga_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       row_in,
  output logic [W-1:0]       row_next
);

  logic [2:0] col [W];

  for (genvar i = 0; i < W; i++) begin : g_cell
    logic [2:0] left_col;
    logic [2:0] right_col;

    if (i == 0) begin : g_left_edge
      assign left_col = 3'b000;
    end else begin : g_left
      assign left_col = col[i-1];
    end

    if (i == W - 1) begin : g_right_edge
      assign right_col = 3'b000;
    end else begin : g_right
      assign right_col = col[i+1];
    end

    lga_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_bit    (row_in[i]),
      .left_col  (left_col),
      .right_col (right_col),
      .col       (col[i]),
      .next_bit  (row_next[i])
    );
  end

endmodule

// File: hw/rtl/lga_row_mem.sv
// Grid row memory with one write and one registered read port; unwritten rows read as dead.
module lga_row_mem #(
  parameter int W = 64,
  parameter int H = 64,
  localparam int AW = $clog2(H)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data
);

  logic [W-1:0] mem [H];
  logic [H-1:0] row_valid;
  logic [W-1:0] rd_q;
  logic         rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

// File: hw/rtl/life_grid_automaton_unit.sv
// Top level of the life grid automaton: request decoding, tick sequencer and result register.
//
// The grid is kept one row per word in a row memory and starts all dead after reset,
// with no clearing pass. A tick sweeps the rows once through a row of GRID_WIDTH cells
// that hold three rows and compute one new row per cycle, through the single read and
// single write port of the row memory. A read or write that hits the grid goes through
// a row read, then bit select or read-modify-write, then the result register; a read
// or write outside the grid, or a request with the unused command code, goes straight
// to the result register. One request is worked on at a time; the next request
// may be taken while the previous result still waits in the output register.
`include "life_grid_automaton_unit_macros.svh"

module life_grid_automaton_unit #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic         clk,
  input  logic         rst,
  lga_stream_if.sink   req,
  lga_stream_if.source rsp
);

  localparam int AW = $clog2(GRID_HEIGHT);
  localparam int XW = $clog2(GRID_WIDTH);
  localparam int SW = $clog2(GRID_HEIGHT + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_SWEEP  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]          state;
  logic [1:0]          cmd_q;
  logic [XW-1:0]       x_q;
  logic [AW-1:0]       y_q;
  logic                alive_q;
  logic                res_q;
  logic [SW-1:0]       sweep_cnt;
  logic                out_valid;
  lga_pkg::rsp_t       out_q;

  logic                accept;
  logic                in_grid;
  logic                mem_rd_en;
  logic [AW-1:0]       mem_rd_addr;
  logic [GRID_WIDTH-1:0] mem_rd_data;
  logic                mem_wr_en;
  logic [AW-1:0]       mem_wr_addr;
  logic [GRID_WIDTH-1:0] mem_wr_data;
  logic [GRID_WIDTH-1:0] row_in;
  logic [GRID_WIDTH-1:0] row_next;
  lga_pkg::cell_ctl_t  cell_ctl;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_grid   = (int'(req.payload.cell_x) < GRID_WIDTH) &&
                     (int'(req.payload.cell_y) < GRID_HEIGHT);

  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = row_next;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.payload.command == lga_pkg::CMD_TICK) begin
            mem_rd_en = 1'b1;
          end else if (in_grid && (req.payload.command == lga_pkg::CMD_WRITE ||
                                   req.payload.command == lga_pkg::CMD_READ)) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(req.payload.cell_y);
          end
        end
      end
      ST_ACCESS: begin
        if (cmd_q == lga_pkg::CMD_WRITE) begin
          mem_wr_en          = 1'b1;
          mem_wr_addr        = y_q;
          mem_wr_data        = mem_rd_data;
          mem_wr_data[x_q]   = alive_q;
        end
      end
      ST_SWEEP: begin
        if (int'(sweep_cnt) + 1 < GRID_HEIGHT) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = AW'(sweep_cnt + 1'b1);
        end
        if (sweep_cnt != '0) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = AW'(sweep_cnt - 1'b1);
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  assign row_in = (int'(sweep_cnt) < GRID_HEIGHT) ? mem_rd_data : '0;

  assign cell_ctl.clr   = accept && (req.payload.command == lga_pkg::CMD_TICK);
  assign cell_ctl.shift = (state == ST_SWEEP);

  lga_row_mem #(
    .W (GRID_WIDTH),
    .H (GRID_HEIGHT)
  ) u_row_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  lga_cell_row #(
    .W (GRID_WIDTH)
  ) u_cell_row (
    .clk      (clk),
    .ctl      (cell_ctl),
    .row_in   (row_in),
    .row_next (row_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= req.payload.command;
            x_q     <= XW'(req.payload.cell_x);
            y_q     <= AW'(req.payload.cell_y);
            alive_q <= req.payload.new_alive;
            res_q   <= 1'b0;
            if (req.payload.command == lga_pkg::CMD_TICK) begin
              sweep_cnt <= '0;
              state     <= ST_SWEEP;
            end else if (in_grid && (req.payload.command == lga_pkg::CMD_WRITE ||
                                     req.payload.command == lga_pkg::CMD_READ)) begin
              state <= ST_ACCESS;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_ACCESS: begin
          res_q <= (cmd_q == lga_pkg::CMD_WRITE) ? alive_q : mem_rd_data[x_q];
          state <= ST_FINISH;
        end
        ST_SWEEP: begin
          if (sweep_cnt == SW'(GRID_HEIGHT)) begin
            state <= ST_FINISH;
          end else begin
            sweep_cnt <= sweep_cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid          <= 1'b1;
            out_q.cell_alive   <= res_q;
            out_q.done_command <= cmd_q;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.payload = out_q;

  `LGA_ASSERT_NOW(a_wr_phase, mem_wr_en,
                  (state == ST_SWEEP && sweep_cnt != '0) ||
                  (state == ST_ACCESS && cmd_q == lga_pkg::CMD_WRITE))
  `LGA_ASSERT_NEXT(a_tick_starts, accept && req.payload.command == lga_pkg::CMD_TICK,
                   state == ST_SWEEP && sweep_cnt == '0)
  `LGA_ASSERT_NEXT(a_sweep_ends, state == ST_SWEEP && sweep_cnt == SW'(GRID_HEIGHT),
                   state == ST_FINISH)
  `LGA_ASSERT_NOW(a_rsp_from_finish, $rose(rsp.valid), $past(state) == ST_FINISH)

endmodule

// File: tb/life_grid_automaton_unit_tb.sv
// Self-checking testbench of the life grid automaton: directed and random requests, predicted results.
`timescale 1ns / 1ps

module life_grid_automaton_unit_tb;

  localparam int GRID_W = 64;
  localparam int GRID_H = 64;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = GRID_H + 40;
  localparam int IDLE_LIMIT = 4000;

  typedef struct {
    lga_pkg::req_t rq;
    bit            typed;
    lga_pkg::rsp_t rs;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lga_stream_if #(.payload_t(lga_pkg::req_t)) req_ch ();
  lga_stream_if #(.payload_t(lga_pkg::rsp_t)) rsp_ch ();

  life_grid_automaton_unit #(
    .GRID_WIDTH(GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  bit [GRID_W-1:0] cell_state [GRID_H];
  lga_pkg::rsp_t pending_results [$];
  stim_row_t life_table [$];
  int error_count = 0;
  int sent_count = 0;
  int taken_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int rx_wait = 0;
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;
  lga_pkg::rsp_t got_rsp;
  lga_pkg::rsp_t want_rsp;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    foreach (cell_state[r]) cell_state[r] = '0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    $display("life_grid_automaton_unit_tb: mismatch: %s", what);
    error_count++;
  endtask

  task automatic advance_generation();
    bit [GRID_W-1:0] next_state [GRID_H];
    int live;
    int nr;
    int nc;
    for (int r = 0; r < GRID_H; r++) begin
      for (int c = 0; c < GRID_W; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            nr = r + dr;
            nc = c + dc;
            if ((dr != 0 || dc != 0) && nr >= 0 && nr < GRID_H && nc >= 0 && nc < GRID_W)
              live += cell_state[nr][nc];
          end
        end
        next_state[r][c] = (live == 3) || (cell_state[r][c] && live == 2);
      end
    end
    cell_state = next_state;
  endtask

  task automatic predict_cell_command(input lga_pkg::req_t rq, output lga_pkg::rsp_t rs);
    bit on_grid;
    on_grid = (rq.cell_x < GRID_W) && (rq.cell_y < GRID_H);
    rs.cell_alive = 1'b0;
    rs.done_command = rq.command;
    case (rq.command)
      lga_pkg::CMD_WRITE: begin
        if (on_grid) begin
          cell_state[rq.cell_y][rq.cell_x] = rq.new_alive;
          rs.cell_alive = rq.new_alive;
        end
      end
      lga_pkg::CMD_TICK: begin
        advance_generation();
      end
      lga_pkg::CMD_READ: begin
        if (on_grid) rs.cell_alive = cell_state[rq.cell_y][rq.cell_x];
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input lga_pkg::req_t rq, input bit typed,
                              input lga_pkg::rsp_t typed_rs);
    lga_pkg::rsp_t predicted;
    int gap;
    if (sent_count % 40 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    req_ch.payload <= rq;
    req_ch.valid <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predict_cell_command(rq, predicted);
    pending_results.push_back(typed ? typed_rs : predicted);
    sent_count++;
    gap = calm_tx ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_cell(input logic [1:0] cmd, input int x, input int y, input bit alive);
    lga_pkg::req_t rq;
    rq.command = cmd;
    rq.cell_x = x[5:0];
    rq.cell_y = y[5:0];
    rq.new_alive = alive;
    send_request(rq, 1'b0, '0);
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic stim_row_t life_row(logic [1:0] cmd, int x, int y, bit alive, bit typed,
                                         bit exp_alive);
    stim_row_t row;
    row.rq.command = cmd;
    row.rq.cell_x = x[5:0];
    row.rq.cell_y = y[5:0];
    row.rq.new_alive = alive;
    row.typed = typed;
    row.rs.cell_alive = exp_alive;
    row.rs.done_command = cmd;
    return row;
  endfunction

  // The left-edge blinker and the corner cells would interact if the edges wrapped.
  initial begin
    life_table.push_back(life_row(lga_pkg::CMD_READ, 0, 0, 1'b0, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 63, 63, 1'b1, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 0, 0, 1'b1, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 63, 63, 1'b1, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 0, 63, 1'b0, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 0, 0, 1'b0, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 63, 63, 1'b0, 1'b1, 1'b1));
    life_table.push_back(life_row(CMD_UNUSED, 63, 63, 1'b1, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 0, 63, 1'b1, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 0, 1, 1'b1, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 0, 2, 1'b1, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 62, 63, 1'b1, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 63, 62, 1'b1, 1'b1, 1'b1));
    life_table.push_back(life_row(lga_pkg::CMD_TICK, 0, 0, 1'b0, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 0, 0, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 1, 1, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 0, 1, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 62, 62, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 63, 0, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_TICK, 63, 63, 1'b1, 1'b1, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 0, 1, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 62, 62, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_READ, 63, 63, 1'b0, 1'b0, 1'b0));
    life_table.push_back(life_row(lga_pkg::CMD_WRITE, 0, 0, 1'b0, 1'b1, 1'b0));
  end

  initial begin
    int base_x;
    int base_y;
    int n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (life_table[i]) send_request(life_table[i].rq, life_table[i].typed, life_table[i].rs);
    wait_for_results();
    while (sent_count < life_table.size() + RANDOM_ITEMS) begin
      n = $urandom_range(0, 3);
      base_x = (n == 0) ? 0 : (n == 1) ? GRID_W - 8 : $urandom_range(0, GRID_W - 8);
      n = $urandom_range(0, 3);
      base_y = (n == 0) ? 0 : (n == 1) ? GRID_H - 8 : $urandom_range(0, GRID_H - 8);
      n = $urandom_range(6, 16);
      repeat (n) send_cell(lga_pkg::CMD_WRITE, base_x + $urandom_range(0, 7),
                           base_y + $urandom_range(0, 7), $urandom_range(0, 3) != 0);
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_cell(lga_pkg::CMD_TICK, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
        repeat ($urandom_range(3, 8))
          send_cell(lga_pkg::CMD_READ, base_x + $urandom_range(0, 7),
                    base_y + $urandom_range(0, 7), 1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(0, 3))
        send_cell(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("life_grid_automaton_unit_tb: done, clean");
    end else begin
      $display("life_grid_automaton_unit_tb: done, errors");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= 0;
    end else if (rsp_ch.ready) begin
      if (rsp_ch.valid) begin
        taken_count++;
        if (taken_count % 40 == 0) calm_rx = ($urandom_range(0, 3) == 0);
        rx_wait = calm_rx ? 0 : $urandom_range(0, 6);
        if (rx_wait != 0) begin
          rsp_ch.ready <= 1'b0;
          stall_left <= rx_wait;
        end
      end
    end else begin
      if (stall_left <= 1) rsp_ch.ready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_rsp = rsp_ch.payload;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: alive %0b command %0d",
                                  got_rsp.cell_alive, got_rsp.done_command));
      end else begin
        want_rsp = pending_results.pop_front();
        if (got_rsp.cell_alive !== want_rsp.cell_alive)
          report_mismatch($sformatf("cell_alive %0b, expected %0b (command %0d)",
                                    got_rsp.cell_alive, want_rsp.cell_alive,
                                    want_rsp.done_command));
        if (got_rsp.done_command !== want_rsp.done_command)
          report_mismatch($sformatf("done_command %0d, expected %0d",
                                    got_rsp.done_command, want_rsp.done_command));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("life_grid_automaton_unit_tb: no request or result moved for %0d cycles",
               idle_cycles);
      $display("life_grid_automaton_unit_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: life_grid_automaton_unit.f
+incdir+hw/rtl
hw/rtl/lga_pkg.sv
hw/rtl/lga_stream_if.sv
hw/rtl/lga_cell.sv
hw/rtl/lga_cell_row.sv
hw/rtl/lga_row_mem.sv
hw/rtl/life_grid_automaton_unit.sv
tb/life_grid_automaton_unit_tb.sv
